// ===== rtl/dpe_pkg.sv =====
// dpe_pkg: shared types, constants and micro-program of the permittivity evaluator
// depends on nothing; used by dpe_cdiv, dpe_dp, dpe_ctrl and dispersive_permittivity_eval

package dpe_pkg;

	localparam int DATA_W    = 32;
	localparam int FRAC_BITS = 16;
	localparam int MAX_TERMS = 16;
	localparam int IDX_W     = $clog2(MAX_TERMS);
	localparam int CNT_W     = IDX_W + 1;
	localparam int TCNT_W    = 5;
	localparam int PROD_W    = 2 * DATA_W;
	localparam int WIDE_W    = PROD_W + 2;
	localparam int QBITS     = DATA_W - 1;
	localparam int DIV_W     = PROD_W + QBITS;
	localparam int ROW_W     = 2 + 5 * DATA_W;
	localparam int PC_W      = 5;
	localparam int MSTEP_W   = 3;
	localparam int DSTEP_W   = $clog2(QBITS + 1);
	localparam int CFG_IDX_W = 2;

	localparam logic [DATA_W-1:0] S32_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic [DATA_W-1:0] S32_MIN = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic [DATA_W-1:0] Q_ONE   = DATA_W'(1) << FRAC_BITS;
	localparam logic signed [WIDE_W-1:0] WIDE_MAX = WIDE_W'(2147483647);
	localparam logic signed [WIDE_W-1:0] WIDE_MIN = -WIDE_MAX - WIDE_W'(1);

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_EPS_INF    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TERM_COUNT = 2'd1;

	// input opcodes and term kinds
	localparam logic OPC_LOAD = 1'b0;
	localparam logic OPC_EVAL = 1'b1;
	localparam logic [1:0] KIND_DEBYE   = 2'd0;
	localparam logic [1:0] KIND_DRUDE   = 2'd1;
	localparam logic [1:0] KIND_LORENTZ = 2'd2;
	localparam logic [1:0] KIND_CP      = 2'd3;

	typedef enum logic [2:0] {OP_MUL, OP_ADD, OP_SUB, OP_NEG, OP_CDIV} op_t;

	typedef enum logic [4:0] {
		R_ZERO, R_ONE, R_A, R_B, R_C, R_D, R_E, R_W, R_X, R_AO,
		R_NR, R_NI, R_DR, R_DI, R_R1, R_I1, R_SR, R_SI, R_QR, R_QI
	} reg_t;

	typedef struct packed {
		op_t  op;
		reg_t sa;
		reg_t sb;
		reg_t dst;
		logic last;
	} uinstr_t;

	typedef enum logic [1:0] {CS_IDLE, CS_CHECK, CS_RUN, CS_RESULT} ctrl_state_t;
	typedef enum logic [1:0] {DV_IDLE, DV_MUL, DV_CHECK, DV_DIV} div_state_t;

	typedef struct packed {
		logic             mem_we;
		logic             eval_init;
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic             issue;
		uinstr_t          ui;
		logic             emit;
	} cmd_t;

	typedef struct packed {
		logic              busy;
		logic [1:0]        kind;
		logic [TCNT_W-1:0] term_cnt;
	} status_t;

	// saturate a wide signed value to 32 bits, flag in the top bit
	function automatic logic [DATA_W:0] sat_w(input logic signed [WIDE_W-1:0] v);
		logic [DATA_W:0] r;
		if (v > WIDE_MAX) begin
			r = {1'b1, S32_MAX};
		end else if (v < WIDE_MIN) begin
			r = {1'b1, S32_MIN};
		end else begin
			r = {1'b0, v[DATA_W-1:0]};
		end
		return r;
	endfunction

	// sign and magnitude of a wrapped numerator; the pattern 2^63 counts as positive
	function automatic logic [PROD_W:0] num_mag(input logic [PROD_W-1:0] w);
		logic neg;
		logic [PROD_W-1:0] m;
		neg = w[PROD_W-1] && (|w[PROD_W-2:0]);
		m = neg ? (PROD_W'(0) - w) : w;
		return {neg, m};
	endfunction

	function automatic uinstr_t mk(input op_t op, input reg_t sa, input reg_t sb,
		input reg_t dst, input logic last);
		uinstr_t u;
		u.op = op;
		u.sa = sa;
		u.sb = sb;
		u.dst = dst;
		u.last = last;
		return u;
	endfunction

	// micro-program for one term, by kind and step
	function automatic uinstr_t ucode(input logic [1:0] kind, input logic [PC_W-1:0] pc);
		uinstr_t u;
		u = mk(OP_ADD, R_ZERO, R_ZERO, R_X, 1'b1);
		unique case (kind)
			KIND_DEBYE: begin
				case (pc)
					5'd0: u = mk(OP_MUL, R_W, R_B, R_X, 1'b0);
					5'd1: u = mk(OP_NEG, R_X, R_ZERO, R_DI, 1'b0);
					5'd2: u = mk(OP_ADD, R_A, R_ZERO, R_NR, 1'b0);
					5'd3: u = mk(OP_ADD, R_ZERO, R_ZERO, R_NI, 1'b0);
					5'd4: u = mk(OP_ADD, R_ONE, R_ZERO, R_DR, 1'b0);
					5'd5: u = mk(OP_CDIV, R_ZERO, R_ZERO, R_X, 1'b0);
					5'd6: u = mk(OP_ADD, R_SR, R_QR, R_SR, 1'b0);
					5'd7: u = mk(OP_ADD, R_SI, R_QI, R_SI, 1'b1);
					default: u = mk(OP_ADD, R_ZERO, R_ZERO, R_X, 1'b1);
				endcase
			end
			KIND_DRUDE: begin
				case (pc)
					5'd0: u = mk(OP_MUL, R_A, R_A, R_X, 1'b0);
					5'd1: u = mk(OP_NEG, R_X, R_ZERO, R_NR, 1'b0);
					5'd2: u = mk(OP_ADD, R_ZERO, R_ZERO, R_NI, 1'b0);
					5'd3: u = mk(OP_MUL, R_W, R_W, R_DR, 1'b0);
					5'd4: u = mk(OP_MUL, R_W, R_B, R_DI, 1'b0);
					5'd5: u = mk(OP_CDIV, R_ZERO, R_ZERO, R_X, 1'b0);
					5'd6: u = mk(OP_ADD, R_SR, R_QR, R_SR, 1'b0);
					5'd7: u = mk(OP_ADD, R_SI, R_QI, R_SI, 1'b1);
					default: u = mk(OP_ADD, R_ZERO, R_ZERO, R_X, 1'b1);
				endcase
			end
			KIND_LORENTZ: begin
				case (pc)
					5'd0: u = mk(OP_MUL, R_B, R_B, R_X, 1'b0);
					5'd1: u = mk(OP_MUL, R_A, R_X, R_NR, 1'b0);
					5'd2: u = mk(OP_ADD, R_ZERO, R_ZERO, R_NI, 1'b0);
					5'd3: u = mk(OP_MUL, R_W, R_W, R_DR, 1'b0);
					5'd4: u = mk(OP_SUB, R_X, R_DR, R_DR, 1'b0);
					5'd5: u = mk(OP_MUL, R_W, R_C, R_DI, 1'b0);
					5'd6: u = mk(OP_NEG, R_DI, R_ZERO, R_DI, 1'b0);
					5'd7: u = mk(OP_CDIV, R_ZERO, R_ZERO, R_X, 1'b0);
					5'd8: u = mk(OP_ADD, R_SR, R_QR, R_SR, 1'b0);
					5'd9: u = mk(OP_ADD, R_SI, R_QI, R_SI, 1'b1);
					default: u = mk(OP_ADD, R_ZERO, R_ZERO, R_X, 1'b1);
				endcase
			end
			KIND_CP: begin
				case (pc)
					5'd0:  u = mk(OP_MUL, R_A, R_B, R_AO, 1'b0);
					5'd1:  u = mk(OP_ADD, R_D, R_ZERO, R_NR, 1'b0);
					5'd2:  u = mk(OP_ADD, R_E, R_ZERO, R_NI, 1'b0);
					5'd3:  u = mk(OP_SUB, R_B, R_W, R_DR, 1'b0);
					5'd4:  u = mk(OP_NEG, R_C, R_ZERO, R_DI, 1'b0);
					5'd5:  u = mk(OP_CDIV, R_ZERO, R_ZERO, R_X, 1'b0);
					5'd6:  u = mk(OP_ADD, R_QR, R_ZERO, R_R1, 1'b0);
					5'd7:  u = mk(OP_ADD, R_QI, R_ZERO, R_I1, 1'b0);
					5'd8:  u = mk(OP_NEG, R_E, R_ZERO, R_NI, 1'b0);
					5'd9:  u = mk(OP_ADD, R_B, R_W, R_DR, 1'b0);
					5'd10: u = mk(OP_ADD, R_C, R_ZERO, R_DI, 1'b0);
					5'd11: u = mk(OP_CDIV, R_ZERO, R_ZERO, R_X, 1'b0);
					5'd12: u = mk(OP_ADD, R_R1, R_QR, R_X, 1'b0);
					5'd13: u = mk(OP_MUL, R_AO, R_X, R_X, 1'b0);
					5'd14: u = mk(OP_ADD, R_SR, R_X, R_SR, 1'b0);
					5'd15: u = mk(OP_ADD, R_I1, R_QI, R_X, 1'b0);
					5'd16: u = mk(OP_MUL, R_AO, R_X, R_X, 1'b0);
					5'd17: u = mk(OP_ADD, R_SI, R_X, R_SI, 1'b1);
					default: u = mk(OP_ADD, R_ZERO, R_ZERO, R_X, 1'b1);
				endcase
			end
		endcase
		return u;
	endfunction

endpackage

// ===== rtl/dpe_cdiv.sv =====
// dpe_cdiv: complex fixed-point divide n * conj(d) / |d|^2 with saturation
// depends on dpe_pkg; one 32x32 multiplier and a 32-step restoring divider

module dpe_cdiv (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [dpe_pkg::DATA_W-1:0]  nr,
	input  logic signed [dpe_pkg::DATA_W-1:0]  ni,
	input  logic signed [dpe_pkg::DATA_W-1:0]  dr,
	input  logic signed [dpe_pkg::DATA_W-1:0]  di,
	output logic                               busy,
	output logic signed [dpe_pkg::DATA_W-1:0]  qr,
	output logic signed [dpe_pkg::DATA_W-1:0]  qi,
	output logic                               ovf_evt
);

	dpe_pkg::div_state_t state_q, state_d;

	logic signed [dpe_pkg::DATA_W-1:0] nr_q, ni_q, dr_q, di_q;
	logic [dpe_pkg::MSTEP_W-1:0] mstep_q, pstep_s1;
	logic pv_s1;
	logic signed [dpe_pkg::PROD_W-1:0] p_s1;
	logic [dpe_pkg::PROD_W-1:0] den_q, nre_q, nim_q;
	logic [dpe_pkg::DIV_W-1:0] r_q, d_q;
	logic [dpe_pkg::QBITS-1:0] q_q, qn;
	logic neg_q, part_q, ovf_evt_q;
	logic [dpe_pkg::DSTEP_W-1:0] step_q;
	logic signed [dpe_pkg::DATA_W-1:0] qr_q, qi_q;

	logic signed [dpe_pkg::DATA_W-1:0] ma, mb;
	logic mul_go, ge, finish, den_zero;
	logic [dpe_pkg::PROD_W:0] mag_re, mag_im;
	logic [dpe_pkg::DATA_W-1:0] divres;

	localparam logic [dpe_pkg::MSTEP_W-1:0] MSTEP_END = 3'd6;
	localparam logic [dpe_pkg::DSTEP_W-1:0] STEP_END = dpe_pkg::DSTEP_W'(dpe_pkg::QBITS);

	always_comb begin
		unique case (mstep_q)
			3'd0: begin ma = dr_q; mb = dr_q; end
			3'd1: begin ma = di_q; mb = di_q; end
			3'd2: begin ma = nr_q; mb = dr_q; end
			3'd3: begin ma = ni_q; mb = di_q; end
			3'd4: begin ma = ni_q; mb = dr_q; end
			default: begin ma = nr_q; mb = di_q; end
		endcase
	end

	assign mul_go   = (state_q == dpe_pkg::DV_MUL) && (mstep_q != MSTEP_END);
	assign den_zero = (den_q == '0);
	assign ge       = (r_q >= d_q);
	assign qn       = {q_q[dpe_pkg::QBITS-2:0], ge};
	assign finish   = ((step_q == '0) && ge) || (step_q == STEP_END);
	assign mag_re   = dpe_pkg::num_mag(nre_q);
	assign mag_im   = dpe_pkg::num_mag(nim_q);

	// quotient with sign, or the clamp when the first step already fits
	always_comb begin
		if (step_q == '0) begin
			divres = neg_q ? dpe_pkg::S32_MIN : dpe_pkg::S32_MAX;
		end else if (neg_q) begin
			divres = dpe_pkg::DATA_W'(0) - {1'b0, qn};
		end else begin
			divres = {1'b0, qn};
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dpe_pkg::DV_IDLE: begin
				if (start) state_d = dpe_pkg::DV_MUL;
			end
			dpe_pkg::DV_MUL: begin
				if (mstep_q == MSTEP_END) state_d = dpe_pkg::DV_CHECK;
			end
			dpe_pkg::DV_CHECK: begin
				state_d = den_zero ? dpe_pkg::DV_IDLE : dpe_pkg::DV_DIV;
			end
			dpe_pkg::DV_DIV: begin
				if (finish && part_q) state_d = dpe_pkg::DV_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= dpe_pkg::DV_IDLE;
			pv_s1     <= 1'b0;
			ovf_evt_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			pv_s1     <= mul_go;
			ovf_evt_q <= ((state_q == dpe_pkg::DV_CHECK) && den_zero) ||
				((state_q == dpe_pkg::DV_DIV) && (step_q == '0) && ge);
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == dpe_pkg::DV_IDLE) && start) begin
			nr_q    <= nr;
			ni_q    <= ni;
			dr_q    <= dr;
			di_q    <= di;
			mstep_q <= '0;
		end
		if (mul_go) begin
			p_s1     <= ma * mb;
			pstep_s1 <= mstep_q;
			mstep_q  <= mstep_q + 3'd1;
		end
		// exact 64-bit sums, wrapping like the numerators they stand for
		if (pv_s1) begin
			unique case (pstep_s1)
				3'd0: den_q <= p_s1;
				3'd1: den_q <= den_q + p_s1;
				3'd2: nre_q <= p_s1;
				3'd3: nre_q <= nre_q + p_s1;
				3'd4: nim_q <= p_s1;
				default: nim_q <= nim_q - p_s1;
			endcase
		end
		if (state_q == dpe_pkg::DV_CHECK) begin
			if (den_zero) begin
				qr_q <= '0;
				qi_q <= '0;
			end else begin
				r_q    <= dpe_pkg::DIV_W'(mag_re[dpe_pkg::PROD_W-1:0]) << dpe_pkg::FRAC_BITS;
				d_q    <= dpe_pkg::DIV_W'(den_q) << dpe_pkg::QBITS;
				neg_q  <= mag_re[dpe_pkg::PROD_W];
				step_q <= '0;
				part_q <= 1'b0;
				q_q    <= '0;
			end
		end
		if (state_q == dpe_pkg::DV_DIV) begin
			if (finish) begin
				if (!part_q) begin
					qr_q   <= divres;
					r_q    <= dpe_pkg::DIV_W'(mag_im[dpe_pkg::PROD_W-1:0]) << dpe_pkg::FRAC_BITS;
					d_q    <= dpe_pkg::DIV_W'(den_q) << dpe_pkg::QBITS;
					neg_q  <= mag_im[dpe_pkg::PROD_W];
					step_q <= '0;
					part_q <= 1'b1;
					q_q    <= '0;
				end else begin
					qi_q <= divres;
				end
			end else begin
				if (ge) r_q <= r_q - d_q;
				q_q    <= qn;
				d_q    <= d_q >> 1;
				step_q <= step_q + 1'b1;
			end
		end
	end

	assign busy    = (state_q != dpe_pkg::DV_IDLE) || ovf_evt_q;
	assign qr      = qr_q;
	assign qi      = qi_q;
	assign ovf_evt = ovf_evt_q;

endmodule

// ===== rtl/dpe_dp.sv =====
// dpe_dp: datapath with term table, working registers, multiplier, alu and complex divider
// depends on dpe_pkg and dpe_cdiv; driven by commands from dpe_ctrl

module dpe_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  dpe_pkg::cmd_t                        cmd,
	input  logic                                 cfg_we,
	input  logic [dpe_pkg::CFG_IDX_W-1:0]        cfg_idx,
	input  logic [dpe_pkg::DATA_W-1:0]           cfg_wdata,
	input  logic [3:0]                           ld_index,
	input  logic [1:0]                           ld_kind,
	input  logic [5*dpe_pkg::DATA_W-1:0]         ld_params,
	input  logic signed [dpe_pkg::DATA_W-1:0]    frequency,
	output dpe_pkg::status_t                     st,
	output logic [dpe_pkg::DATA_W-1:0]           res_real,
	output logic [dpe_pkg::DATA_W-1:0]           res_imag,
	output logic                                 res_ovf
);

	logic [dpe_pkg::ROW_W-1:0] mem [dpe_pkg::MAX_TERMS];
	logic [dpe_pkg::ROW_W-1:0] rd_q;
	logic mem_wr;

	logic signed [dpe_pkg::DATA_W-1:0] eps_inf_q;
	logic [dpe_pkg::TCNT_W-1:0] term_cnt_q;

	logic signed [dpe_pkg::DATA_W-1:0] w_q, x_q, ao_q, nr_q, ni_q, dr_q, di_q;
	logic signed [dpe_pkg::DATA_W-1:0] r1_q, i1_q, sr_q, si_q;
	logic ovf_q;

	logic signed [dpe_pkg::DATA_W-1:0] pa, pb, pc, pd, pe, opa, opb, qr, qi;
	logic signed [dpe_pkg::PROD_W-1:0] prod_s1;
	dpe_pkg::reg_t mdst_s1;
	logic mul_v_s1;

	logic signed [dpe_pkg::WIDE_W-1:0] alu_wide, rnd;
	logic [dpe_pkg::DATA_W:0] alu_sat, mul_sat;
	logic alu_en, wb_en, wb_ovf, div_busy, div_ovf, div_go;
	dpe_pkg::reg_t wb_dst;
	logic [dpe_pkg::DATA_W-1:0] wb_val;

	assign pa = rd_q[2 +: dpe_pkg::DATA_W];
	assign pb = rd_q[2 + dpe_pkg::DATA_W +: dpe_pkg::DATA_W];
	assign pc = rd_q[2 + 2*dpe_pkg::DATA_W +: dpe_pkg::DATA_W];
	assign pd = rd_q[2 + 3*dpe_pkg::DATA_W +: dpe_pkg::DATA_W];
	assign pe = rd_q[2 + 4*dpe_pkg::DATA_W +: dpe_pkg::DATA_W];

	// loads beyond the table are dropped
	assign mem_wr = cmd.mem_we && (32'(ld_index) < dpe_pkg::MAX_TERMS);

	always_ff @(posedge clk) begin
		if (mem_wr) mem[dpe_pkg::IDX_W'(ld_index)] <= {ld_params, ld_kind};
		if (cmd.rd_en) rd_q <= mem[cmd.rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_inf_q  <= dpe_pkg::Q_ONE;
			term_cnt_q <= '0;
			mul_v_s1   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					dpe_pkg::CFG_EPS_INF:    eps_inf_q  <= cfg_wdata;
					dpe_pkg::CFG_TERM_COUNT: term_cnt_q <= cfg_wdata[dpe_pkg::TCNT_W-1:0];
					default: ;
				endcase
			end
			mul_v_s1 <= cmd.issue && (cmd.ui.op == dpe_pkg::OP_MUL);
		end
	end

	function automatic logic signed [dpe_pkg::DATA_W-1:0] pick(input dpe_pkg::reg_t s);
		logic signed [dpe_pkg::DATA_W-1:0] v;
		unique case (s)
			dpe_pkg::R_ZERO: v = '0;
			dpe_pkg::R_ONE:  v = dpe_pkg::Q_ONE;
			dpe_pkg::R_A:    v = pa;
			dpe_pkg::R_B:    v = pb;
			dpe_pkg::R_C:    v = pc;
			dpe_pkg::R_D:    v = pd;
			dpe_pkg::R_E:    v = pe;
			dpe_pkg::R_W:    v = w_q;
			dpe_pkg::R_X:    v = x_q;
			dpe_pkg::R_AO:   v = ao_q;
			dpe_pkg::R_NR:   v = nr_q;
			dpe_pkg::R_NI:   v = ni_q;
			dpe_pkg::R_DR:   v = dr_q;
			dpe_pkg::R_DI:   v = di_q;
			dpe_pkg::R_R1:   v = r1_q;
			dpe_pkg::R_I1:   v = i1_q;
			dpe_pkg::R_SR:   v = sr_q;
			dpe_pkg::R_SI:   v = si_q;
			dpe_pkg::R_QR:   v = qr;
			dpe_pkg::R_QI:   v = qi;
			default:         v = '0;
		endcase
		return v;
	endfunction

	always_comb begin
		opa = pick(cmd.ui.sa);
		opb = pick(cmd.ui.sb);
	end

	// multiplier: product registered, then round half up, shift and clamp
	always_ff @(posedge clk) begin
		if (cmd.issue && (cmd.ui.op == dpe_pkg::OP_MUL)) begin
			prod_s1 <= opa * opb;
			mdst_s1 <= cmd.ui.dst;
		end
	end

	assign rnd = (dpe_pkg::WIDE_W'(prod_s1) +
		(dpe_pkg::WIDE_W'(1) <<< (dpe_pkg::FRAC_BITS - 1))) >>> dpe_pkg::FRAC_BITS;
	assign mul_sat = dpe_pkg::sat_w(rnd);

	always_comb begin
		alu_wide = '0;
		alu_en = 1'b0;
		if (cmd.issue) begin
			unique case (cmd.ui.op)
				dpe_pkg::OP_ADD: begin
					alu_wide = dpe_pkg::WIDE_W'(opa) + dpe_pkg::WIDE_W'(opb);
					alu_en = 1'b1;
				end
				dpe_pkg::OP_SUB: begin
					alu_wide = dpe_pkg::WIDE_W'(opa) - dpe_pkg::WIDE_W'(opb);
					alu_en = 1'b1;
				end
				dpe_pkg::OP_NEG: begin
					alu_wide = dpe_pkg::WIDE_W'(0) - dpe_pkg::WIDE_W'(opa);
					alu_en = 1'b1;
				end
				default: ;
			endcase
		end
	end

	assign alu_sat = dpe_pkg::sat_w(alu_wide);

	always_comb begin
		if (mul_v_s1) begin
			wb_en  = 1'b1;
			wb_dst = mdst_s1;
			wb_val = mul_sat[dpe_pkg::DATA_W-1:0];
			wb_ovf = mul_sat[dpe_pkg::DATA_W];
		end else begin
			wb_en  = alu_en;
			wb_dst = cmd.ui.dst;
			wb_val = alu_sat[dpe_pkg::DATA_W-1:0];
			wb_ovf = alu_en && alu_sat[dpe_pkg::DATA_W];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.eval_init) begin
			w_q   <= frequency;
			sr_q  <= eps_inf_q;
			si_q  <= '0;
			ovf_q <= 1'b0;
		end else begin
			if ((wb_en && wb_ovf) || div_ovf) ovf_q <= 1'b1;
			if (wb_en) begin
				case (wb_dst)
					dpe_pkg::R_X:  x_q  <= wb_val;
					dpe_pkg::R_AO: ao_q <= wb_val;
					dpe_pkg::R_NR: nr_q <= wb_val;
					dpe_pkg::R_NI: ni_q <= wb_val;
					dpe_pkg::R_DR: dr_q <= wb_val;
					dpe_pkg::R_DI: di_q <= wb_val;
					dpe_pkg::R_R1: r1_q <= wb_val;
					dpe_pkg::R_I1: i1_q <= wb_val;
					dpe_pkg::R_SR: sr_q <= wb_val;
					dpe_pkg::R_SI: si_q <= wb_val;
					default: ;
				endcase
			end
		end
	end

	assign div_go = cmd.issue && (cmd.ui.op == dpe_pkg::OP_CDIV);

	dpe_cdiv u_cdiv (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_go),
		.nr      (nr_q),
		.ni      (ni_q),
		.dr      (dr_q),
		.di      (di_q),
		.busy    (div_busy),
		.qr      (qr),
		.qi      (qi),
		.ovf_evt (div_ovf)
	);

	assign st.busy     = mul_v_s1 || div_busy;
	assign st.kind     = rd_q[1:0];
	assign st.term_cnt = term_cnt_q;

	assign res_real = sr_q;
	assign res_imag = si_q;
	assign res_ovf  = ovf_q;

endmodule

// ===== rtl/dpe_ctrl.sv =====
// dpe_ctrl: sequencer that walks the term table and steps each term's micro-program
// depends on dpe_pkg; commands dpe_dp and reads its status

module dpe_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_opcode,
	input  logic              out_busy,
	input  dpe_pkg::status_t  st,
	output logic              in_ready,
	output dpe_pkg::cmd_t     cmd
);

	dpe_pkg::ctrl_state_t state_q, state_d;
	logic [dpe_pkg::CNT_W-1:0] t_q, t_d;
	logic [dpe_pkg::PC_W-1:0] pc_q, pc_d;
	logic terms_done;
	dpe_pkg::uinstr_t ui;

	// term count above the table size sums the whole table
	assign terms_done = (32'(t_q) >= 32'(st.term_cnt)) || (32'(t_q) >= dpe_pkg::MAX_TERMS);
	assign ui = dpe_pkg::ucode(st.kind, pc_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dpe_pkg::CS_IDLE;
			t_q     <= '0;
			pc_q    <= '0;
		end else begin
			state_q <= state_d;
			t_q     <= t_d;
			pc_q    <= pc_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		t_d      = t_q;
		pc_d     = pc_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.ui   = ui;
		unique case (state_q)
			dpe_pkg::CS_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_opcode == dpe_pkg::OPC_EVAL) begin
						cmd.eval_init = 1'b1;
						t_d = '0;
						state_d = dpe_pkg::CS_CHECK;
					end else begin
						cmd.mem_we = 1'b1;
					end
				end
			end
			dpe_pkg::CS_CHECK: begin
				if (terms_done) begin
					state_d = dpe_pkg::CS_RESULT;
				end else begin
					cmd.rd_en = 1'b1;
					cmd.rd_addr = t_q[dpe_pkg::IDX_W-1:0];
					pc_d = '0;
					state_d = dpe_pkg::CS_RUN;
				end
			end
			dpe_pkg::CS_RUN: begin
				if (!st.busy) begin
					cmd.issue = 1'b1;
					if (ui.last) begin
						t_d = t_q + 1'b1;
						state_d = dpe_pkg::CS_CHECK;
					end else begin
						pc_d = pc_q + 1'b1;
					end
				end
			end
			dpe_pkg::CS_RESULT: begin
				if (!out_busy) begin
					cmd.emit = 1'b1;
					state_d = dpe_pkg::CS_IDLE;
				end
			end
		endcase
	end

endmodule

// ===== rtl/dispersive_permittivity_eval.sv =====
// dispersive_permittivity_eval: top level of the complex permittivity evaluator
// depends on dpe_pkg, dpe_ctrl, dpe_dp (and dpe_cdiv below it)
//
//  channel   | direction | transfer when                 | carries
//  s_axis    | in        | s_axis_tvalid & s_axis_tready | load a term entry or evaluate at w
//  m_axis    | out       | m_axis_tvalid & m_axis_tready | real, imaginary part, overflow
//  cfg       | in        | cfg_valid & cfg_ready         | eps_inf (index 0), term_count (1)
//
// a load is written to the term table when it is taken; each term adds to the evaluation time,
// which is set by the complex divider: six multiplies, then two 32-step restoring divisions per
// divide, with two divides for a critical-point term and one for Debye, Drude or Lorentz
// one item is in flight at a time; the result waits in the output register while the
// next item is already taken, and a stalled result holds the evaluation in its last step
// reset clears control state and sets eps_inf to 1.0 and term_count to 0; the term table
// is not cleared and must be loaded before it is used

module dispersive_permittivity_eval (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// term_index[3:0], term_kind[5:4], param_a[37:6], param_b[69:38], param_c[101:70],
	// param_d[133:102], param_e[165:134], frequency[197:166], zero fill[199:198]
	input  logic [199:0] s_axis_tdata,
	// opcode[0]
	input  logic         s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// eps_real[31:0], eps_imag[63:32], overflow[64], zero fill[71:65]
	output logic [71:0]  m_axis_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	localparam int OUT_W = 72;

	dpe_pkg::cmd_t    cmd;
	dpe_pkg::status_t st;

	logic [dpe_pkg::DATA_W-1:0] res_real, res_imag;
	logic res_ovf;
	logic out_valid_q;
	logic [OUT_W-1:0] out_data_q;
	logic out_busy;

	// configuration is always taken at once
	assign cfg_ready = 1'b1;

	// result slot is free when empty or being drained this cycle
	assign out_busy = out_valid_q && !m_axis_tready;

	dpe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_opcode (s_axis_tuser),
		.out_busy  (out_busy),
		.st        (st),
		.in_ready  (s_axis_tready),
		.cmd       (cmd)
	);

	dpe_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_idx   (cfg_index),
		.cfg_wdata (cfg_data),
		.ld_index  (s_axis_tdata[3:0]),
		.ld_kind   (s_axis_tdata[5:4]),
		.ld_params (s_axis_tdata[165:6]),
		.frequency (s_axis_tdata[197:166]),
		.st        (st),
		.res_real  (res_real),
		.res_imag  (res_imag),
		.res_ovf   (res_ovf)
	);

	// output register between the sequencer and the result channel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) out_data_q <= {7'd0, res_ovf, res_imag, res_real};
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

`ifndef SYNTHESIS
	// a new result never lands on one that has not been taken
	a_emit_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!m_axis_tvalid || m_axis_tready))
		else $error("result written over a pending result");

	// the input side only opens once multiplier and divider are quiet
	a_ready_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !st.busy)
		else $error("input ready while datapath busy");

	// a micro-op is never issued while an earlier one is still in flight
	a_issue_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> !st.busy)
		else $error("micro-op issued while datapath busy");

	// an evaluation start is followed by a table walk, not another transfer
	a_eval_walk: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.eval_init |=> !s_axis_tready)
		else $error("input taken during an evaluation");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
// testbench for dispersive_permittivity_eval: directed table, then random load/evaluate traffic
// checks every result against a fixed-point permittivity predictor here or a typed value
// depends on dpe_pkg and the dispersive_permittivity_eval rtl

module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import dpe_pkg::*;

	localparam longint SMAX = 64'sd2147483647;
	localparam longint SMIN = -64'sd2147483648;
	localparam longint QONE = 64'sd65536;
	localparam int IDLE_LIMIT = 40000;
	localparam int SETTLE_CYCLES = 30;

	// one step of stimulus: either a register write or a stream item
	typedef struct {
		bit          is_cfg;
		logic [1:0]  cidx;
		logic [31:0] cval;
		logic        opc;
		logic [3:0]  idx;
		logic [1:0]  kind;
		logic [31:0] a, b, c, d, e, w;
		bit          typed;
		logic [31:0] t_re, t_im;
		logic        t_ov;
	} step_t;

	typedef struct {
		logic [31:0] re;
		logic [31:0] im;
		logic        ov;
	} eps_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [199:0] s_axis_tdata;
	logic         s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [71:0]  m_axis_tdata;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [1:0]   cfg_index;
	logic [31:0]  cfg_data;

	dispersive_permittivity_eval dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// 8 ns clock
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predictor state: registers and term table as the block should hold them
	longint   pm_eps_inf;
	int       pm_count;
	bit [1:0] pm_kind [MAX_TERMS];
	longint   pm_par [MAX_TERMS][5];
	bit       pm_ovf;

	eps_t eps_q[$];
	int   errors;
	int   idle_cycles;
	int   burst_left;

	// ---------------- fixed-point arithmetic of the block ----------------

	function automatic longint clamp32(longint v);
		if (v > SMAX) begin
			pm_ovf = 1'b1;
			return SMAX;
		end
		if (v < SMIN) begin
			pm_ovf = 1'b1;
			return SMIN;
		end
		return v;
	endfunction

	// product rounded half up, then saturated
	function automatic longint qmul(longint x, longint y);
		return clamp32((x * y + 64'sd32768) >>> FRAC_BITS);
	endfunction

	// one quotient half of a complex divide; the pattern 2^63 counts as positive
	function automatic longint quot_part(bit [63:0] wr, bit [63:0] den);
		bit        neg;
		bit [63:0] mag, q, r;
		neg = wr[63] && (wr[62:0] != 0);
		mag = neg ? (64'd0 - wr) : wr;
		q = mag / den;
		r = mag % den;
		if ((q >> (31 - FRAC_BITS)) != 0) begin
			pm_ovf = 1'b1;
			return neg ? SMIN : SMAX;
		end
		for (int i = 0; i < FRAC_BITS; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= den) begin
				r = r - den;
				q[0] = 1'b1;
			end
		end
		return neg ? -longint'(q) : longint'(q);
	endfunction

	// n * conj(d) / |d|^2; a zero denominator gives zero and flags overflow
	task automatic cplx_div(input longint nr, ni, dr, di, output longint qr, qi);
		bit [63:0] den;
		den = 64'(dr * dr) + 64'(di * di);
		if (den == 0) begin
			pm_ovf = 1'b1;
			qr = 0;
			qi = 0;
		end else begin
			qr = quot_part(64'(nr * dr) + 64'(ni * di), den);
			qi = quot_part(64'(ni * dr - nr * di), den);
		end
	endtask

	// contribution of one table entry at frequency w
	task automatic term_value(input int t, input longint w, output longint re, im);
		longint a, b, c, d, e, x, y, ao, r1, i1, r2, i2;
		a = pm_par[t][0];
		b = pm_par[t][1];
		c = pm_par[t][2];
		d = pm_par[t][3];
		e = pm_par[t][4];
		case (pm_kind[t])
			KIND_DEBYE: begin
				cplx_div(a, 0, QONE, clamp32(-qmul(w, b)), re, im);
			end
			KIND_DRUDE: begin
				x = qmul(a, a);
				cplx_div(clamp32(-x), 0, qmul(w, w), qmul(w, b), re, im);
			end
			KIND_LORENTZ: begin
				x = qmul(b, b);
				y = qmul(a, x);
				cplx_div(y, 0, clamp32(x - qmul(w, w)), clamp32(-qmul(w, c)), re, im);
			end
			default: begin
				ao = qmul(a, b);
				cplx_div(d, e, clamp32(b - w), clamp32(-c), r1, i1);
				cplx_div(d, clamp32(-e), clamp32(b + w), c, r2, i2);
				re = qmul(ao, clamp32(r1 + r2));
				im = qmul(ao, clamp32(i1 + i2));
			end
		endcase
	endtask

	// permittivity sum for an evaluate transfer
	task automatic permittivity_at(input longint w, output eps_t res);
		longint sr, si, re, im;
		int n;
		pm_ovf = 1'b0;
		n = (pm_count > MAX_TERMS) ? MAX_TERMS : pm_count;
		sr = pm_eps_inf;
		si = 0;
		for (int t = 0; t < n; t++) begin
			term_value(t, w, re, im);
			sr = clamp32(sr + re);
			si = clamp32(si + im);
		end
		res.re = sr[31:0];
		res.im = si[31:0];
		res.ov = pm_ovf;
	endtask

	// ---------------- stimulus rows ----------------

	function automatic step_t row_cfg(logic [1:0] idx, logic [31:0] val);
		step_t s;
		s = '{default: '0};
		s.is_cfg = 1'b1;
		s.cidx = idx;
		s.cval = val;
		return s;
	endfunction

	// load with a random frequency field, which the block ignores
	function automatic step_t row_load(logic [3:0] idx, logic [1:0] kind,
		logic [31:0] a, b, c, d, e);
		step_t s;
		s = '{default: '0};
		s.opc = OPC_LOAD;
		s.idx = idx;
		s.kind = kind;
		s.a = a;
		s.b = b;
		s.c = c;
		s.d = d;
		s.e = e;
		s.w = $urandom;
		return s;
	endfunction

	// evaluate with random junk in the fields it ignores
	function automatic step_t row_eval(logic [31:0] w, bit typed = 0,
		logic [31:0] re = '0, logic [31:0] im = '0, logic ov = 1'b0);
		step_t s;
		s = row_load(4'($urandom), 2'($urandom), $urandom, $urandom, $urandom, $urandom,
			$urandom);
		s.opc = OPC_EVAL;
		s.w = w;
		s.typed = typed;
		s.t_re = re;
		s.t_im = im;
		s.t_ov = ov;
		return s;
	endfunction

	// parameter value: mostly a few units wide, sometimes any word
	function automatic logic [31:0] rand_q();
		if ($urandom_range(0, 3) == 0) begin
			return $urandom;
		end
		return 32'($signed($urandom_range(0, 524288)) - 262144);
	endfunction

	// ---------------- drivers ----------------

	// send one stream item; valid stays high inside a burst, drops for a gap after it
	task automatic send_item(input step_t s);
		eps_t res;
		@(negedge clk);
		s_axis_tdata = {2'b00, s.w, s.e, s.d, s.c, s.b, s.a, s.kind, s.idx};
		s_axis_tuser = s.opc;
		s_axis_tvalid = 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		// transfer taken: update the predictor in the same step
		if (s.opc == OPC_LOAD) begin
			pm_kind[s.idx] = s.kind;
			pm_par[s.idx][0] = longint'($signed(s.a));
			pm_par[s.idx][1] = longint'($signed(s.b));
			pm_par[s.idx][2] = longint'($signed(s.c));
			pm_par[s.idx][3] = longint'($signed(s.d));
			pm_par[s.idx][4] = longint'($signed(s.e));
		end else begin
			permittivity_at(longint'($signed(s.w)), res);
			if (s.typed) begin
				res.re = s.t_re;
				res.im = s.t_im;
				res.ov = s.t_ov;
			end
			eps_q.push_back(res);
		end
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 24);
			@(negedge clk);
			s_axis_tvalid = 1'b0;
			repeat ($urandom_range(0, 6)) @(negedge clk);
		end
	endtask

	// close the burst, then wait until every result is back and the block has settled
	task automatic drain();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (eps_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// register write, issued only with the block idle
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		drain();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		cfg_index = idx;
		cfg_data = val;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_EPS_INF) begin
			pm_eps_inf = longint'($signed(val));
		end else if (idx == CFG_TERM_COUNT) begin
			pm_count = int'(val[4:0]);
		end
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic run_step(input step_t s);
		if (s.is_cfg) begin
			write_reg(s.cidx, s.cval);
		end else begin
			send_item(s);
		end
	endtask

	// ---------------- result checking ----------------

	always @(posedge clk) begin
		eps_t x;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (eps_q.size() == 0) begin
				$error("result transfer with nothing expected: %h", m_axis_tdata);
				errors++;
			end else begin
				x = eps_q.pop_front();
				if (m_axis_tdata[31:0] !== x.re) begin
					$error("eps_real expected %h got %h", x.re, m_axis_tdata[31:0]);
					errors++;
				end
				if (m_axis_tdata[63:32] !== x.im) begin
					$error("eps_imag expected %h got %h", x.im, m_axis_tdata[63:32]);
					errors++;
				end
				if (m_axis_tdata[64] !== x.ov) begin
					$error("overflow expected %b got %b", x.ov, m_axis_tdata[64]);
					errors++;
				end
			end
		end
	end

	// receiver: stretches of steady ready, then stretches of random stalls
	int  rx_left;
	bit  rx_stall;
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_stall = $urandom_range(0, 1);
			rx_left = $urandom_range(1, 60);
		end
		rx_left--;
		m_axis_tready = rx_stall ? ($urandom_range(0, 2) == 0) : 1'b1;
	end

	// watchdog: too long without any transfer ends the run
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
			|| (cfg_valid && cfg_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL dispersive_permittivity_eval");
			$finish;
		end
	end

	// ---------------- main sequence ----------------

	step_t table_rows[$];
	step_t s;

	initial begin
		errors = 0;
		idle_cycles = 0;
		burst_left = 4;
		rx_left = 0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		m_axis_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		pm_eps_inf = QONE;
		pm_count = 0;
		arst_n = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		table_rows = '{
			// reset state: eps_inf 1.0, no terms
			row_eval(32'h0, 1, 32'h0001_0000, 32'h0, 1'b0),
			// drude at w = 0 divides by zero
			row_load(4'd0, KIND_DRUDE, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0),
			row_cfg(CFG_TERM_COUNT, 32'd1),
			row_eval(32'h0, 1, 32'h0001_0000, 32'h0, 1'b1),
			row_eval(32'h0001_0000),
			// sum clamps at the top
			row_load(4'd0, KIND_DEBYE, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0),
			row_cfg(CFG_EPS_INF, 32'h7fff_ffff),
			row_eval(32'h0, 1, 32'h7fff_ffff, 32'h0, 1'b1),
			row_cfg(CFG_EPS_INF, 32'h8000_0000),
			row_eval(32'h8000_0000),
			row_load(4'd0, KIND_LORENTZ, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
				32'h0, 32'h0),
			row_eval(32'h7fff_ffff),
			row_load(4'd0, KIND_CP, 32'h0001_0000, 32'h0002_0000, 32'h0000_8000,
				32'h0001_0000, 32'h0),
			row_cfg(CFG_EPS_INF, 32'h0),
			row_eval(32'h0001_0000),
			row_load(4'd1, KIND_CP, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
				32'h8000_0000, 32'h8000_0000),
			row_cfg(CFG_TERM_COUNT, 32'd2),
			row_eval(32'h8000_0000),
			row_load(4'd15, KIND_LORENTZ, 32'h0001_0000, 32'h0001_0000, 32'h0000_4000,
				32'hffff_ffff, 32'hffff_ffff),
			// count above the table size sums the whole table
			row_cfg(CFG_TERM_COUNT, 32'd31),
			row_eval(32'h0000_8000),
			// unused register indexes change nothing
			row_cfg(2'd2, 32'hffff_ffff),
			row_cfg(2'd3, 32'h5a5a_a5a5),
			row_eval(32'h7fff_ffff)
		};

		// every entry is written before any count can reach it
		for (int i = 0; i < MAX_TERMS; i++) begin
			send_item(row_load(4'(i), KIND_DEBYE, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0));
		end
		foreach (table_rows[i]) begin
			run_step(table_rows[i]);
		end

		// random phases: registers change between phases, with the block drained
		for (int ph = 0; ph < 10; ph++) begin
			case ($urandom_range(0, 3))
				0: write_reg(CFG_EPS_INF, $urandom);
				default: write_reg(CFG_EPS_INF, rand_q());
			endcase
			case ($urandom_range(0, 9))
				0: write_reg(CFG_TERM_COUNT, 32'($urandom_range(16, 31)));
				1: write_reg(CFG_TERM_COUNT, 32'd0);
				default: write_reg(CFG_TERM_COUNT, 32'($urandom_range(1, 5)));
			endcase
			for (int k = 0; k < 85; k++) begin
				if ($urandom_range(0, 9) < 4) begin
					s = row_load(4'($urandom), 2'($urandom), rand_q(), rand_q(), rand_q(),
						rand_q(), rand_q());
				end else begin
					s = row_eval(rand_q());
				end
				send_item(s);
			end
		end

		@(negedge clk);
		s_axis_tvalid = 1'b0;
		drain();
		if (errors == 0) begin
			$display("PASS dispersive_permittivity_eval");
		end else begin
			$display("FAIL dispersive_permittivity_eval");
		end
		$finish;
	end

endmodule
